/* rtl/core/cht_pkg.sv */
`timescale 1ns / 1ps

package cht_pkg;

    localparam int BUCKET_COUNT = 256;
    localparam int POOL_DEPTH   = 1024;

    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int BUCKET_W = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;

    // heads sit at 0 .. BUCKET_COUNT-1, pool nodes follow them
    localparam int NODE_DEPTH = BUCKET_COUNT + POOL_DEPTH;
    localparam int NODE_AW    = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
    // link holds a pool index, or POOL_DEPTH for end of chain
    localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
    localparam int BKT_IW     = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CREATED = 3'd0,
        STAT_UPDATED = 3'd1,
        STAT_FOUND   = 3'd2,
        STAT_MISS    = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_FIND   = 1'b1
    } action_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [LINK_W-1:0]  link;
    } node_t;

    typedef struct packed {
        logic               rd_en;
        logic [NODE_AW-1:0] rd_addr;
        logic               wr_en;
        logic [NODE_AW-1:0] wr_addr;
        node_t              wr_data;
    } mem_req_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value_out;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

/* rtl/core/cht_node_ram.sv */
`timescale 1ns / 1ps

module cht_node_ram (
    input  logic              clk,
    input  cht_pkg::mem_req_t req,
    output cht_pkg::node_t    rd_data
);

    cht_pkg::node_t mem [cht_pkg::NODE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* rtl/core/cht_ctrl.sv */
`timescale 1ns / 1ps

module cht_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [cht_pkg::KEY_W-1:0]     key,
    input  logic [cht_pkg::VALUE_W-1:0]   value_in,
    input  logic [cht_pkg::BUCKET_W-1:0]  bucket,
    output logic                          res_valid,
    output cht_pkg::result_t              res,
    input  logic                          res_take,
    output cht_pkg::mem_req_t             mem_req,
    input  cht_pkg::node_t                rd_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_LINK = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam logic [cht_pkg::LINK_W-1:0] LINK_END = cht_pkg::LINK_W'(cht_pkg::POOL_DEPTH);

    state_t state_reg, state_next;
    logic [cht_pkg::BUCKET_COUNT-1:0] head_valid_reg, head_valid_next;
    logic [cht_pkg::LINK_W-1:0]  pool_used_reg, pool_used_next;
    logic [cht_pkg::COUNT_W-1:0] entries_reg, entries_next;

    logic                         action_reg, action_next;
    logic [cht_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [cht_pkg::VALUE_W-1:0]  val_reg, val_next;
    logic [cht_pkg::NODE_AW-1:0]  cur_addr_reg, cur_addr_next;
    cht_pkg::node_t               cur_node_reg, cur_node_next;
    logic [cht_pkg::LINK_W-1:0]   new_link_reg, new_link_next;
    cht_pkg::result_t             res_reg, res_next;

    logic                         key_hit;
    logic                         chain_end;
    logic                         pool_full;
    logic                         bucket_oor;
    logic [cht_pkg::BKT_IW-1:0]   bkt_idx;
    logic [cht_pkg::NODE_AW-1:0]  next_addr;
    logic [cht_pkg::NODE_AW-1:0]  alloc_addr;

    // shared compare unit, one chain node per cycle
    assign key_hit    = (rd_data.key == key_reg);
    assign chain_end  = (32'(rd_data.link) >= cht_pkg::POOL_DEPTH);
    assign pool_full  = (32'(pool_used_reg) >= cht_pkg::POOL_DEPTH);
    assign bucket_oor = (32'(bucket) >= cht_pkg::BUCKET_COUNT);
    assign bkt_idx    = cht_pkg::BKT_IW'(bucket);
    assign next_addr  = cht_pkg::NODE_AW'(cht_pkg::BUCKET_COUNT)
                      + cht_pkg::NODE_AW'(rd_data.link);
    assign alloc_addr = cht_pkg::NODE_AW'(cht_pkg::BUCKET_COUNT)
                      + cht_pkg::NODE_AW'(pool_used_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        pool_used_next  = pool_used_reg;
        entries_next    = entries_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        cur_addr_next   = cur_addr_reg;
        cur_node_next   = cur_node_reg;
        new_link_next   = new_link_reg;
        res_next        = res_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    key_next    = key;
                    val_next    = value_in;
                    res_next.value_out   = '0;
                    res_next.entry_count = entries_reg;
                    if (bucket_oor)
                    begin
                        res_next.status = (action == cht_pkg::ACT_FIND) ?
                                          cht_pkg::STAT_MISS : cht_pkg::STAT_FULL;
                        state_next = ST_DONE;
                    end
                    else if (!head_valid_reg[bkt_idx])
                    begin
                        if (action == cht_pkg::ACT_FIND)
                        begin
                            res_next.status = cht_pkg::STAT_MISS;
                        end
                        else
                        begin
                            mem_req.wr_en         = 1'b1;
                            mem_req.wr_addr       = cht_pkg::NODE_AW'(bucket);
                            mem_req.wr_data.key   = key;
                            mem_req.wr_data.value = value_in;
                            mem_req.wr_data.link  = LINK_END;
                            head_valid_next[bkt_idx] = 1'b1;
                            entries_next         = entries_reg + 1'b1;
                            res_next.status      = cht_pkg::STAT_CREATED;
                            res_next.entry_count = entries_reg + 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = cht_pkg::NODE_AW'(bucket);
                        cur_addr_next   = cht_pkg::NODE_AW'(bucket);
                        state_next      = ST_WALK;
                    end
                end
            end

            ST_WALK:
            begin
                if (key_hit)
                begin
                    if (action_reg == cht_pkg::ACT_FIND)
                    begin
                        res_next.status    = cht_pkg::STAT_FOUND;
                        res_next.value_out = rd_data.value;
                    end
                    else
                    begin
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = cur_addr_reg;
                        mem_req.wr_data.key   = rd_data.key;
                        mem_req.wr_data.value = val_reg;
                        mem_req.wr_data.link  = rd_data.link;
                        res_next.status       = cht_pkg::STAT_UPDATED;
                    end
                    state_next = ST_DONE;
                end
                else if (chain_end)
                begin
                    if (action_reg == cht_pkg::ACT_FIND)
                    begin
                        res_next.status = cht_pkg::STAT_MISS;
                        state_next      = ST_DONE;
                    end
                    else if (pool_full)
                    begin
                        res_next.status = cht_pkg::STAT_FULL;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        // new tail node now, relink the old tail next cycle
                        mem_req.wr_en         = 1'b1;
                        mem_req.wr_addr       = alloc_addr;
                        mem_req.wr_data.key   = key_reg;
                        mem_req.wr_data.value = val_reg;
                        mem_req.wr_data.link  = LINK_END;
                        cur_node_next  = rd_data;
                        new_link_next  = pool_used_reg;
                        pool_used_next = pool_used_reg + 1'b1;
                        entries_next   = entries_reg + 1'b1;
                        res_next.status      = cht_pkg::STAT_CREATED;
                        res_next.entry_count = entries_reg + 1'b1;
                        state_next     = ST_LINK;
                    end
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = next_addr;
                    cur_addr_next   = next_addr;
                end
            end

            ST_LINK:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = cur_addr_reg;
                mem_req.wr_data.key   = cur_node_reg.key;
                mem_req.wr_data.value = cur_node_reg.value;
                mem_req.wr_data.link  = new_link_reg;
                state_next            = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_valid_reg <= '0;
            pool_used_reg  <= '0;
            entries_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_valid_reg <= head_valid_next;
            pool_used_reg  <= pool_used_next;
            entries_reg    <= entries_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        cur_addr_reg <= cur_addr_next;
        cur_node_reg <= cur_node_next;
        new_link_reg <= new_link_next;
        res_reg      <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pool_used_reg) <= cht_pkg::POOL_DEPTH)
        else $error("pool allocation count beyond pool depth");

    a_walk_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> $past(mem_req.rd_en))
        else $error("chain compare without a node read the cycle before");

    a_link_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> ($past(state_reg) == ST_WALK))
        else $error("tail relink not preceded by a chain walk");

    a_one_port_use: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.rd_en && mem_req.wr_en))
        else $error("node memory read and written in the same cycle");

    a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LINK) |-> (pool_used_reg == $past(pool_used_reg) + 1'b1))
        else $error("append did not take a pool node");

endmodule

/* rtl/core/chained_hash_table.sv */
`timescale 1ns / 1ps
// an insert or find on an empty bucket gives its result without a chain walk
// chain walk: one node read and key compare per cycle; an insert that appends a pool node
// relinks the old tail in the link state after the walk
// one item at a time: tready is high only while the sequencer is idle
// reset (rst_n low, asynchronous) empties all buckets and the pool, no clearing pass

module chained_hash_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key[31:0], value_in[63:32], bucket[71:64]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value_out[31:0], entry_count[42:32], zero fill
    output logic [2:0]  m_axis_tuser    // status
);

    cht_pkg::mem_req_t mem_req;
    cht_pkg::node_t    rd_data;
    cht_pkg::result_t  res;
    cht_pkg::result_t  out_reg;
    logic              res_valid;
    logic              res_take;
    logic              out_valid_reg;

    cht_node_ram u_ram (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    cht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .key       (s_axis_tdata[31:0]),
        .value_in  (s_axis_tdata[63:32]),
        .bucket    (s_axis_tdata[71:64]),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // output register frees the sequencer while a result waits downstream
    assign res_take = res_valid && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {5'b0, out_reg.entry_count, out_reg.value_out};

endmodule
